// ===== rtl/fga_pkg.sv =====
// Shared types, constants and step functions of the foot ground alignment block.
// Depends on nothing; used by foot_ground_alignment_top.
package fga_pkg;

	// one input item
	typedef struct packed {
		logic signed [31:0] foot_x;
		logic signed [31:0] foot_y;
		logic signed [31:0] foot_z;
		logic               ray_hit;
		logic signed [31:0] hit_x;
		logic signed [31:0] hit_y;
		logic signed [31:0] hit_z;
		logic signed [15:0] normal_x;
		logic signed [15:0] normal_y;
		logic signed [15:0] normal_z;
	} item_t;

	// one result item
	typedef struct packed {
		logic signed [31:0] target_x;
		logic signed [31:0] target_y;
		logic signed [31:0] target_z;
		logic [16:0]        blend_weight;
		logic               grounded;
		logic signed [15:0] rot_w;
		logic signed [15:0] rot_x;
		logic signed [15:0] rot_y;
		logic signed [15:0] rot_z;
	} result_t;

	// configuration register indexes
	typedef enum logic [2:0] {
		CFG_FOOT_HEIGHT = 3'd0,
		CFG_MAX_STEP    = 3'd1,
		CFG_UP_X        = 3'd2,
		CFG_UP_Y        = 3'd3,
		CFG_UP_Z        = 3'd4
	} cfg_idx_t;

	// one lane of the radix-2 restoring divider, remainder kept below den
	typedef struct packed {
		logic [31:0] den;
		logic [31:0] rem;
		logic [30:0] lo;
		logic [30:0] quo;
	} div_t;

	// one lane of the radix-4 digit square root
	typedef struct packed {
		logic [63:0] v;
		logic [35:0] rem;
		logic [31:0] root;
	} sq_t;

	localparam logic signed [15:0] Q14_ONE    = 16'sd16384;
	localparam logic signed [32:0] ONE30      = 33'sd1073741824;
	// c * 1000 >= 999 * 2^30 exactly when c reaches this value
	localparam logic signed [31:0] COS_LIM    = 32'sd1072668083;
	// squared cross length threshold in Q.60: cross length above 0.0001
	localparam logic [63:0]        CROSS_MIN2 = 64'd11529215046;

	// one quotient bit
	function automatic div_t div_step(input div_t d);
		div_t        n;
		logic [32:0] t;
		n = d;
		t = {d.rem, d.lo[30]};
		if (t >= {1'b0, d.den}) begin
			n.rem = 32'(t - {1'b0, d.den});
			n.quo = {d.quo[29:0], 1'b1};
		end else begin
			n.rem = t[31:0];
			n.quo = {d.quo[29:0], 1'b0};
		end
		n.lo = {d.lo[29:0], 1'b0};
		return n;
	endfunction

	// one root bit from two radicand bits
	function automatic sq_t sqrt_step(input sq_t s);
		sq_t         n;
		logic [35:0] t;
		logic [35:0] tr;
		n  = s;
		t  = {s.rem[33:0], s.v[63:62]};
		tr = {2'b00, s.root, 2'b01};
		if (t >= tr) begin
			n.rem  = t - tr;
			n.root = {s.root[30:0], 1'b1};
		end else begin
			n.rem  = t;
			n.root = {s.root[30:0], 1'b0};
		end
		n.v = {s.v[61:0], 2'b00};
		return n;
	endfunction

	// Q.30 magnitude and sign to Q1.14, half away from zero, clamped
	function automatic logic [15:0] to_q14(input logic [30:0] mag, input logic neg);
		logic [31:0] sum;
		logic [15:0] r;
		sum = {1'b0, mag} + 32'd32768;
		r   = sum[31:16];
		if (r > 16'd16384) begin
			r = 16'd16384;
		end
		return neg ? (~r + 16'd1) : r;
	endfunction

endpackage

// ===== rtl/foot_ground_alignment_top.sv =====
// Foot ground alignment block: target position, blend weight and ground rotation.
// Depends on fga_pkg for item, result and arithmetic step types.

// The block takes one item in every clock cycle and never raises busy. Each
// result comes out on result with done high for one cycle, in order; the
// receiver cannot stall it, so results must be taken as they appear. The
// pipeline has three front stages and the bit-serial arithmetic chain: a
// 32-step square root, a 31-step divider, three parallel 32-step square roots
// and a second 31-step divider, one bit per stage.
// Configuration writes take effect at once and must happen only while no item
// is in flight.
module foot_ground_alignment_top
	import fga_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  item_t       item,
	output logic        done,
	output result_t     result,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [31:0] cfg_data
);

	localparam int CH_LEN = 134;
	localparam int LAST   = CH_LEN - 1;

	// front stage payloads
	typedef struct packed {
		logic [2:0][47:0] pfh;
		logic [2:0][31:0] foot;
		logic [2:0][31:0] hit;
		logic             hitf;
		logic [2:0][30:0] uu;
		logic [2:0][30:0] nn;
		logic [2:0][31:0] un;
		logic [2:0][31:0] xa;
		logic [2:0][31:0] xb;
	} prd_t;

	typedef struct packed {
		logic [2:0][31:0] g;
		logic [2:0][31:0] foot;
		logic             hitf;
		logic [31:0]      lu2;
		logic [31:0]      ln2;
		logic [33:0]      dot;
		logic [2:0][33:0] cr;
	} geo_t;

	// chain context
	typedef struct packed {
		logic [2:0][31:0]   tgt;
		logic               near;
		logic               rot;
		logic [16:0]        weight;
		logic [33:0]        rsq;
		logic [33:0]        dot;
		logic [2:0][33:0]   cr;
		logic               dneg;
		logic [2:0]         cneg;
		logic signed [31:0] c;
		logic [2:0][61:0]   esq;
		logic [63:0]        len2;
		logic [2:0][61:0]   pe;
		logic [3:0][15:0]   q;
		div_t [3:0]         dv;
		sq_t [2:0]          sq;
	} ctx_t;

	logic signed [31:0] fh_q;
	logic [30:0]        maxs_q;
	logic signed [15:0] up_q [3];

	item_t  in_s1;
	logic   vld_s1;
	prd_t   prd_s2;
	logic   vld_s2;
	geo_t   geo_s3;
	logic   vld_s3;
	ctx_t   ctx0;
	ctx_t   ctx_s [CH_LEN];
	logic [CH_LEN-1:0] vld_s;

	prd_t prd_d;
	geo_t geo_d;

	// no back pressure anywhere
	assign busy = 1'b0;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fh_q    <= '0;
			maxs_q  <= 31'd32768;
			up_q[0] <= 16'sd0;
			up_q[1] <= 16'sd16384;
			up_q[2] <= 16'sd0;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_FOOT_HEIGHT: fh_q    <= cfg_data;
				CFG_MAX_STEP:    maxs_q  <= cfg_data[30:0];
				CFG_UP_X:        up_q[0] <= cfg_data[15:0];
				CFG_UP_Y:        up_q[1] <= cfg_data[15:0];
				CFG_UP_Z:        up_q[2] <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// item capture
	always_ff @(posedge clk) begin
		in_s1 <= item;
	end

	// products of up with foot height, normal and itself
	always_comb begin
		logic signed [15:0] nv [3];
		logic signed [31:0] fv [3];
		logic signed [31:0] hv [3];
		logic signed [31:0] sqp;
		nv[0] = in_s1.normal_x;
		nv[1] = in_s1.normal_y;
		nv[2] = in_s1.normal_z;
		fv[0] = in_s1.foot_x;
		fv[1] = in_s1.foot_y;
		fv[2] = in_s1.foot_z;
		hv[0] = in_s1.hit_x;
		hv[1] = in_s1.hit_y;
		hv[2] = in_s1.hit_z;
		prd_d = '0;
		prd_d.hitf = in_s1.ray_hit;
		for (int i = 0; i < 3; i++) begin
			prd_d.pfh[i]  = 48'(up_q[i]) * 48'(fh_q);
			prd_d.foot[i] = fv[i];
			prd_d.hit[i]  = hv[i];
			sqp           = 32'(up_q[i]) * 32'(up_q[i]);
			prd_d.uu[i]   = sqp[30:0];
			sqp           = 32'(nv[i]) * 32'(nv[i]);
			prd_d.nn[i]   = sqp[30:0];
			prd_d.un[i]   = 32'(up_q[i]) * 32'(nv[i]);
		end
		prd_d.xa[0] = 32'(up_q[1]) * 32'(nv[2]);
		prd_d.xb[0] = 32'(up_q[2]) * 32'(nv[1]);
		prd_d.xa[1] = 32'(up_q[2]) * 32'(nv[0]);
		prd_d.xb[1] = 32'(up_q[0]) * 32'(nv[2]);
		prd_d.xa[2] = 32'(up_q[0]) * 32'(nv[1]);
		prd_d.xb[2] = 32'(up_q[1]) * 32'(nv[0]);
	end

	always_ff @(posedge clk) begin
		prd_s2 <= prd_d;
	end

	// saturated ground point, lengths, dot and cross
	always_comb begin
		logic signed [47:0] sh;
		logic signed [34:0] sum;
		geo_d = '0;
		geo_d.hitf = prd_s2.hitf;
		for (int i = 0; i < 3; i++) begin
			sh  = $signed(prd_s2.pfh[i]) >>> 14;
			sum = 35'($signed(prd_s2.hit[i])) + 35'(sh);
			if (sum[34:31] == 4'b0000 || sum[34:31] == 4'b1111) begin
				geo_d.g[i] = sum[31:0];
			end else if (sum[34]) begin
				geo_d.g[i] = 32'h8000_0000;
			end else begin
				geo_d.g[i] = 32'h7fff_ffff;
			end
			geo_d.foot[i] = prd_s2.foot[i];
			geo_d.cr[i] = 34'($signed(prd_s2.xa[i])) - 34'($signed(prd_s2.xb[i]));
		end
		geo_d.lu2 = 32'(prd_s2.uu[0]) + 32'(prd_s2.uu[1]) + 32'(prd_s2.uu[2]);
		geo_d.ln2 = 32'(prd_s2.nn[0]) + 32'(prd_s2.nn[1]) + 32'(prd_s2.nn[2]);
		geo_d.dot = 34'($signed(prd_s2.un[0])) + 34'($signed(prd_s2.un[1]))
			+ 34'($signed(prd_s2.un[2]));
	end

	always_ff @(posedge clk) begin
		geo_s3 <= geo_d;
	end

	// front valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// gap test, target pick, weight divider and |up|*|n| root loading
	always_comb begin
		logic signed [32:0] dy;
		logic [32:0]        gap;
		logic               near;
		ctx0 = '0;
		dy   = 33'($signed(geo_s3.g[1])) - 33'($signed(geo_s3.foot[1]));
		gap  = dy[32] ? 33'(-dy) : 33'(dy);
		near = geo_s3.hitf && (gap <= {2'b00, maxs_q});
		ctx0.near = near;
		for (int i = 0; i < 3; i++) begin
			ctx0.tgt[i] = near ? geo_s3.g[i] : geo_s3.foot[i];
		end
		ctx0.dot = geo_s3.dot;
		ctx0.cr  = geo_s3.cr;
		ctx0.sq[0].v    = 64'(geo_s3.lu2) * 64'(geo_s3.ln2);
		ctx0.dv[0].den  = {1'b0, maxs_q};
		ctx0.dv[0].rem  = gap[32:1];
		ctx0.dv[0].lo   = {gap[0], 30'd0};
	end

	// bit-serial chain
	for (genvar j = 0; j < CH_LEN; j++) begin : g_ch
		ctx_t pv;
		ctx_t nx;

		if (j == 0) begin : g_first
			assign pv = ctx0;
		end else begin : g_next
			assign pv = ctx_s[j-1];
		end

		always_comb begin
			logic [16:0]        rq;
			logic [33:0]        mg;
			logic [31:0]        cm;
			logic signed [32:0] hp;
			logic signed [32:0] hm;
			rq = '0;
			mg = '0;
			cm = '0;
			hp = '0;
			hm = '0;
			nx = pv;
			// root of |up|^2 * |n|^2 and the weight quotient
			if (j >= 1 && j <= 32) begin
				nx.sq[0] = sqrt_step(pv.sq[0]);
			end
			if (j >= 1 && j <= 17) begin
				nx.dv[0] = div_step(pv.dv[0]);
			end
			if (j == 18) begin
				rq = (maxs_q == '0) ? '0 : pv.dv[0].quo[16:0];
				nx.rsq = 34'(rq) * 34'(rq);
			end
			if (j == 19) begin
				nx.weight = pv.near ? 17'(18'd65536 - pv.rsq[33:16]) : '0;
			end
			// cosine and cross over m
			if (j == 33) begin
				nx.rot  = pv.near && (pv.sq[0].root != '0);
				nx.dneg = pv.dot[33];
				mg = pv.dot[33] ? 34'(-pv.dot) : pv.dot;
				nx.dv[0].den = pv.sq[0].root;
				nx.dv[0].rem = mg[32:1];
				nx.dv[0].lo  = {mg[0], 30'd0};
				nx.dv[0].quo = '0;
				for (int i = 0; i < 3; i++) begin
					nx.cneg[i] = pv.cr[i][33];
					mg = pv.cr[i][33] ? 34'(-pv.cr[i]) : pv.cr[i];
					nx.dv[i+1].den = pv.sq[0].root;
					nx.dv[i+1].rem = mg[32:1];
					nx.dv[i+1].lo  = {mg[0], 30'd0};
					nx.dv[i+1].quo = '0;
				end
			end
			if (j >= 34 && j <= 64) begin
				for (int k = 0; k < 4; k++) begin
					nx.dv[k] = div_step(pv.dv[k]);
				end
			end
			if (j == 65) begin
				cm   = {1'b0, pv.dv[0].quo};
				nx.c = pv.dneg ? 32'(-cm) : cm;
				for (int i = 0; i < 3; i++) begin
					nx.esq[i] = 62'(pv.dv[i+1].quo) * 62'(pv.dv[i+1].quo);
				end
			end
			if (j == 66) begin
				nx.len2 = 64'(pv.esq[0]) + 64'(pv.esq[1]) + 64'(pv.esq[2]);
				nx.rot  = pv.rot && (pv.c < COS_LIM);
			end
			// cross length and half-angle roots
			if (j == 67) begin
				nx.rot = pv.rot && (pv.len2 > CROSS_MIN2);
				hp = ONE30 + 33'(pv.c);
				hm = ONE30 - 33'(pv.c);
				nx.sq[0] = '{v: pv.len2, rem: '0, root: '0};
				nx.sq[1] = '{v: {3'd0, hp[31:1], 30'd0}, rem: '0, root: '0};
				nx.sq[2] = '{v: {3'd0, hm[31:1], 30'd0}, rem: '0, root: '0};
			end
			if (j >= 68 && j <= 99) begin
				for (int k = 0; k < 3; k++) begin
					nx.sq[k] = sqrt_step(pv.sq[k]);
				end
			end
			// axis components scaled by the half-angle sine
			if (j == 100) begin
				for (int i = 0; i < 3; i++) begin
					nx.pe[i] = 62'(pv.dv[i+1].quo) * 62'(pv.sq[2].root[30:0]);
				end
			end
			if (j == 101) begin
				for (int i = 0; i < 3; i++) begin
					nx.dv[i+1] = '{den: pv.sq[0].root, rem: {1'b0, pv.pe[i][61:31]},
						lo: pv.pe[i][30:0], quo: '0};
				end
			end
			if (j >= 102 && j <= 132) begin
				for (int k = 1; k < 4; k++) begin
					nx.dv[k] = div_step(pv.dv[k]);
				end
			end
			// quaternion rounding, identity when no rotation
			if (j == LAST) begin
				nx.q[0] = pv.rot ? to_q14(pv.sq[1].root[30:0], 1'b0) : Q14_ONE;
				for (int i = 0; i < 3; i++) begin
					nx.q[i+1] = pv.rot ? to_q14(pv.dv[i+1].quo, pv.cneg[i]) : '0;
				end
			end
		end

		always_ff @(posedge clk) begin
			ctx_s[j] <= nx;
		end
	end

	// chain valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[CH_LEN-2:0], vld_s3};
		end
	end

	// result item
	assign done                = vld_s[LAST];
	assign result.target_x     = ctx_s[LAST].tgt[0];
	assign result.target_y     = ctx_s[LAST].tgt[1];
	assign result.target_z     = ctx_s[LAST].tgt[2];
	assign result.blend_weight = ctx_s[LAST].weight;
	assign result.grounded     = ctx_s[LAST].near;
	assign result.rot_w        = ctx_s[LAST].q[0];
	assign result.rot_x        = ctx_s[LAST].q[1];
	assign result.rot_y        = ctx_s[LAST].q[2];
	assign result.rot_z        = ctx_s[LAST].q[3];

endmodule

// ===== sim/tb_foot_ground_alignment_top.sv =====
// Testbench for foot_ground_alignment_top: directed and random items checked against a
// bit-exact predictor of target position, blend weight and ground rotation.
// Depends on fga_pkg and the foot_ground_alignment_top RTL.
module tb_foot_ground_alignment_top;
	import fga_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LATENCY    = 137;
	localparam int WDOG_LIMIT = 4000;
	localparam int N_RANDOM   = 1750;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	item_t       item = '0;
	logic        done;
	result_t     result;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_idx = '0;
	logic [31:0] cfg_data = '0;

	// predictor copy of the registers
	int          foot_height = 0;
	longint      max_step = 32768;
	shortint     up_vec [3] = '{0, 16384, 0};

	result_t     expected_q [$];
	int          mismatches = 0;
	int          idle_cycles = 0;

	foot_ground_alignment_top u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.done(done), .result(result), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// integer square root, floor
	function automatic longint unsigned isqrt(input longint unsigned v);
		longint unsigned res;
		longint unsigned b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	// Q.30 to Q1.14, half away from zero, clamped
	function automatic logic [15:0] round_q14(input longint v);
		longint mag;
		longint r;
		mag = (v < 0) ? -v : v;
		r = (mag + 32768) >>> 16;
		if (r > 16384) r = 16384;
		r = (v < 0) ? -r : r;
		return r[15:0];
	endfunction

	function automatic longint sat32(input longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// expected result of one item under the current register copy
	function automatic result_t predict_alignment(input item_t it);
		result_t         r;
		longint          ft [3];
		longint          ht [3];
		longint          nv [3];
		longint          uv [3];
		longint          tg [3];
		longint          gr [3];
		longint          q [4];
		longint          gap, ratio, weight, d, m, c, w30, s30, ln;
		longint          cr [3];
		longint          e [3];
		longint unsigned lu2, ln2, len2;
		logic            grounded;
		ft = '{it.foot_x, it.foot_y, it.foot_z};
		ht = '{it.hit_x, it.hit_y, it.hit_z};
		nv = '{it.normal_x, it.normal_y, it.normal_z};
		for (int i = 0; i < 3; i++) uv[i] = up_vec[i];
		tg = ft;
		q = '{16384, 0, 0, 0};
		weight = 0;
		grounded = 1'b0;
		if (it.ray_hit) begin
			for (int i = 0; i < 3; i++)
				gr[i] = sat32(ht[i] + ((uv[i] * longint'(foot_height)) >>> 14));
			gap = gr[1] - ft[1];
			if (gap < 0) gap = -gap;
			if (gap <= max_step) begin
				ratio = (max_step != 0) ? (gap << 16) / max_step : 0;
				weight = 65536 - ((ratio * ratio) >>> 16);
				grounded = 1'b1;
				tg = gr;
				lu2 = uv[0] * uv[0] + uv[1] * uv[1] + uv[2] * uv[2];
				ln2 = nv[0] * nv[0] + nv[1] * nv[1] + nv[2] * nv[2];
				d = uv[0] * nv[0] + uv[1] * nv[1] + uv[2] * nv[2];
				m = isqrt(lu2 * ln2);
				if (m > 0) begin
					c = (d <<< 30) / m;
					if (c > (64'sd1 << 30)) c = 64'sd1 << 30;
					if (c < -(64'sd1 << 30)) c = -(64'sd1 << 30);
					if (c * 1000 < 999 * (64'sd1 << 30)) begin
						cr[0] = uv[1] * nv[2] - uv[2] * nv[1];
						cr[1] = uv[2] * nv[0] - uv[0] * nv[2];
						cr[2] = uv[0] * nv[1] - uv[1] * nv[0];
						len2 = 0;
						for (int i = 0; i < 3; i++) begin
							e[i] = (cr[i] <<< 30) / m;
							len2 += e[i] * e[i];
						end
						if (len2 > 64'd11529215046) begin
							ln = isqrt(len2);
							w30 = isqrt(longint'(((64'sd1 << 30) + c) / 2) << 30);
							s30 = isqrt(longint'(((64'sd1 << 30) - c) / 2) << 30);
							q[0] = w30;
							for (int i = 0; i < 3; i++) q[1 + i] = (e[i] * s30) / ln;
						end
					end
				end
			end
		end
		r.target_x = tg[0][31:0];
		r.target_y = tg[1][31:0];
		r.target_z = tg[2][31:0];
		r.blend_weight = weight[16:0];
		r.grounded = grounded;
		r.rot_w = (grounded && q[0] != 16384) ? round_q14(q[0]) : q[0][15:0];
		r.rot_x = round_q14(q[1]);
		r.rot_y = round_q14(q[2]);
		r.rot_z = round_q14(q[3]);
		return r;
	endfunction

	// compare each result with the oldest expectation
	always @(posedge clk) begin
		result_t exp_r;
		if (arst_n && done) begin
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %p", result);
			end else begin
				exp_r = expected_q.pop_front();
				if (result !== exp_r) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch: exp tgt %0d %0d %0d w %0d g %0d q %0d %0d %0d %0d",
							exp_r.target_x, exp_r.target_y, exp_r.target_z,
							exp_r.blend_weight, exp_r.grounded, exp_r.rot_w,
							exp_r.rot_x, exp_r.rot_y, exp_r.rot_z);
						$display("          got tgt %0d %0d %0d w %0d g %0d q %0d %0d %0d %0d",
							result.target_x, result.target_y, result.target_z,
							result.blend_weight, result.grounded, result.rot_w,
							result.rot_x, result.rot_y, result.rot_z);
					end
				end
			end
		end
	end

	// watchdog on cycles with no item moving either way
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WDOG_LIMIT) begin
			$display("** foot_ground_alignment_top: FAILED **");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// send one item and record its expected result once accepted
	task automatic send_item(input item_t it);
		@(negedge clk);
		start = 1'b1;
		item = it;
		do @(posedge clk); while (busy);
		expected_q.push_back(predict_alignment(it));
	endtask

	task automatic idle(input int n);
		repeat (n) begin
			@(negedge clk);
			start = 1'b0;
		end
	endtask

	// stop sending and wait until every expected result is in
	task automatic drain();
		idle(1);
		while (expected_q.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [31:0] v);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_idx = idx;
		cfg_data = v;
		case (idx)
			CFG_FOOT_HEIGHT: foot_height = v;
			CFG_MAX_STEP:    max_step = longint'(v[30:0]);
			CFG_UP_X:        up_vec[0] = v[15:0];
			CFG_UP_Y:        up_vec[1] = v[15:0];
			CFG_UP_Z:        up_vec[2] = v[15:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic set_config(input logic [31:0] fh, input logic [30:0] ms,
		input logic [15:0] ux, input logic [15:0] uy, input logic [15:0] uz);
		write_reg(CFG_FOOT_HEIGHT, fh);
		write_reg(CFG_MAX_STEP, {1'b0, ms});
		write_reg(CFG_UP_X, {16'd0, ux});
		write_reg(CFG_UP_Y, {16'd0, uy});
		write_reg(CFG_UP_Z, {16'd0, uz});
	endtask

	function automatic item_t make_item(input logic signed [31:0] fy, input logic hit,
		input logic signed [31:0] hy, input logic [15:0] nx, input logic [15:0] ny,
		input logic [15:0] nz);
		item_t it;
		it = '0;
		it.foot_x = $urandom;
		it.foot_y = fy;
		it.foot_z = $urandom;
		it.ray_hit = hit;
		it.hit_x = $urandom;
		it.hit_y = hy;
		it.hit_z = $urandom;
		it.normal_x = nx;
		it.normal_y = ny;
		it.normal_z = nz;
		return it;
	endfunction

	// random item, mostly a hit within reach of the max step
	function automatic item_t rand_item();
		item_t        it;
		int           mode;
		longint       off, span, hy;
		logic [255:0] rnd;
		mode = $urandom_range(0, 11);
		rnd = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom};
		it = rnd[$bits(item_t)-1:0];
		if (mode == 0) return it;
		it.ray_hit = (mode != 1);
		off = (longint'(up_vec[1]) * longint'(foot_height)) >>> 14;
		span = (max_step > 64'd1073741824) ? 64'd1073741824 : max_step + 4;
		hy = longint'(it.foot_y) - off + longint'($urandom_range(0, 32'(2 * span))) - span;
		if ($urandom_range(0, 7) == 0) hy = longint'(it.foot_y) - off;
		it.hit_y = 32'(sat32(hy));
		case (mode)
			2: begin
				it.normal_x = up_vec[0] + $signed(4'($urandom));
				it.normal_y = up_vec[1] + $signed(4'($urandom));
				it.normal_z = up_vec[2] + $signed(4'($urandom));
			end
			3: begin
				it.normal_x = -up_vec[0];
				it.normal_y = -up_vec[1];
				it.normal_z = -up_vec[2];
			end
			4: begin
				it.normal_x = 16'($signed(6'($urandom)));
				it.normal_y = 16'($signed(6'($urandom)));
				it.normal_z = 16'($signed(6'($urandom)));
			end
			default: ;
		endcase
		return it;
	endfunction

	task automatic random_burst(input int n);
		int sent;
		int burst;
		sent = 0;
		while (sent < n) begin
			burst = $urandom_range(1, 48);
			for (int k = 0; k < burst && sent < n; k++) begin
				send_item(rand_item());
				sent++;
			end
			if ($urandom_range(0, 3) != 0) idle($urandom_range(1, 9));
		end
	endtask

	// reset values, extremes of the fields, misses and rotation corner cases
	task automatic test_directed();
		send_item(make_item(32'sh7fffffff, 1'b0, 32'sh80000000, 16'h8000, 16'h7fff, 16'h8000));
		send_item(make_item(32'sh80000000, 1'b0, 32'sh7fffffff, 16'h7fff, 16'h8000, 16'h7fff));
		// zero gap, normal equal to up
		send_item(make_item(32'sd1000, 1'b1, 32'sd1000, 16'd0, 16'd16384, 16'd0));
		// gap exactly max step, then one above
		send_item(make_item(32'sd0, 1'b1, 32'sd32768, 16'd16384, 16'd16384, 16'd0));
		send_item(make_item(32'sd0, 1'b1, -32'sd32768, 16'd0, 16'd16384, 16'd16384));
		send_item(make_item(32'sd0, 1'b1, 32'sd32769, 16'd16384, 16'd0, 16'd0));
		send_item(make_item(32'sd0, 1'b1, -32'sd32769, 16'd16384, 16'd0, 16'd0));
		// zero normal
		send_item(make_item(32'sd5, 1'b1, 32'sd5, 16'd0, 16'd0, 16'd0));
		// opposite normal
		send_item(make_item(32'sd7, 1'b1, 32'sd9, 16'd0, 16'hc000, 16'd0));
		// normal extremes, grounded
		send_item(make_item(32'sh7fffffff, 1'b1, 32'sh7fffffff, 16'h8000, 16'h7fff, 16'h8000));
		send_item(make_item(32'sh80000000, 1'b1, 32'sh80000000, 16'h7fff, 16'h8000, 16'h7fff));
		send_item(make_item(32'sd0, 1'b1, 32'sd100, 16'd16384, 16'd1, 16'd0));
		send_item(make_item(32'sd0, 1'b1, 32'sd100, 16'd1, 16'h8000, 16'd1));
		drain();
	endtask

	// register extremes: saturated targets, zero max step, zero up vector
	task automatic test_config_extremes();
		set_config(32'h7fffffff, 31'h7fffffff, 16'h7fff, 16'h7fff, 16'h7fff);
		send_item(make_item(32'sh7fffffff, 1'b1, 32'sh7fffffff, 16'd100, 16'd200, 16'd300));
		send_item(make_item(32'sh80000000, 1'b1, 32'sh80000000, 16'h8000, 16'h8000, 16'h8000));
		random_burst(20);
		drain();
		set_config(32'h80000000, 31'h7fffffff, 16'h8000, 16'h8000, 16'h8000);
		send_item(make_item(32'sh80000000, 1'b1, 32'sh80000000, 16'h7fff, 16'h7fff, 16'h7fff));
		send_item(make_item(32'sh7fffffff, 1'b1, 32'sh7fffffff, 16'd1, 16'd1, 16'd1));
		random_burst(20);
		drain();
		set_config(32'd0, 31'd0, 16'd0, 16'd0, 16'd0);
		send_item(make_item(32'sd3, 1'b1, 32'sd3, 16'd0, 16'd16384, 16'd0));
		send_item(make_item(32'sd3, 1'b1, 32'sd4, 16'd0, 16'd16384, 16'd0));
		drain();
		set_config(32'h00010000, 31'd1, 16'd0, 16'd16384, 16'd0);
		random_burst(20);
		drain();
	endtask

	// random items across several register settings
	task automatic test_random();
		for (int p = 0; p < 7; p++) begin
			case (p)
				0: set_config(32'd0, 31'd32768, 16'd0, 16'd16384, 16'd0);
				1: set_config($urandom_range(0, 32'h20000), 31'($urandom_range(1, 32'h40000)),
					16'd0, 16'd16384, 16'd0);
				2: set_config($urandom, 31'($urandom), 16'($urandom), 16'($urandom),
					16'($urandom));
				3: set_config(32'hfffe0000, 31'h00100000, 16'd11585, 16'd11585, 16'd0);
				4: set_config($urandom, 31'($urandom_range(1, 255)), 16'd0, 16'hc000, 16'd0);
				default: set_config($urandom_range(0, 32'h30000),
					31'($urandom_range(1, 32'h80000)),
					16'($signed(15'($urandom))), 16'($signed(15'($urandom))),
					16'($signed(15'($urandom))));
			endcase
			random_burst(N_RANDOM / 7);
			drain();
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_config_extremes();
		test_random();
		if (mismatches == 0 && expected_q.size() == 0) begin
			$display("** foot_ground_alignment_top: PASSED **");
		end else begin
			$display("** foot_ground_alignment_top: FAILED **");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/fga_pkg.sv
rtl/foot_ground_alignment_top.sv
sim/tb_foot_ground_alignment_top.sv
